// ===== src/heightmap_triangle_sampler_assert.svh =====
// ----------------------------------------------------------------------------
// heightmap_triangle_sampler_assert.svh
// Assertion macros for the heightmap triangle sampler.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_TRIANGLE_SAMPLER_ASSERT_SVH
`define HEIGHTMAP_TRIANGLE_SAMPLER_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define HTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heightmap sampler check failed");

// The consequent must hold in the cycle after the antecedent.
`define HTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heightmap sampler check failed");

`else

`define HTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define HTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/hts_pkg.sv =====
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types and constants of the heightmap triangle sampler.
// ----------------------------------------------------------------------------
package hts_pkg;

    // Item and register field widths.
    localparam int HGT_W   = 32;   // Q16.16 height
    localparam int POS_W   = 25;   // shifted world position, Q.8, signed
    localparam int FRAC_W  = 16;   // cell fraction, Q.16
    localparam int FLO_W   = 10;   // floor cell, signed, -1 .. 511
    localparam int IDX_W   = 22;   // signed linear index, wide enough for any corner index of the map

    // Divider geometry: dividend = pos * map * 256, divisor = world size.
    localparam int DVS_W   = 13;
    localparam int QW      = 25;
    localparam int DVD_W   = DVS_W + QW;
    localparam int QCNT_W  = 5;

    localparam int CORNERS = 4;

    // Operation codes carried in tuser.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Register indexes (byte address / 4).
    localparam logic [2:0] REG_WORLD_WIDTH  = 3'd0;
    localparam logic [2:0] REG_WORLD_DEPTH  = 3'd1;
    localparam logic [2:0] REG_MAP_WIDTH    = 3'd2;
    localparam logic [2:0] REG_MAP_ROWS     = 3'd3;
    localparam logic [2:0] REG_HEIGHT_SCALE = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_GO,
        S_DIV_WAIT,
        S_INDEX,
        S_READ,
        S_FIT_GO,
        S_FIT_WAIT,
        S_DONE
    } t_state;

    // Corner heights and cell fractions handed to the plane fit.
    typedef struct packed {
        logic signed [HGT_W-1:0] p0;
        logic signed [HGT_W-1:0] p1;
        logic signed [HGT_W-1:0] p2;
        logic signed [HGT_W-1:0] p3;
        logic [FRAC_W-1:0]       ox;
        logic [FRAC_W-1:0]       oy;
    } t_fit_in;

endpackage

// ===== src/heightmap_triangle_sampler.sv =====
// A sample passes through the check, the x/y dividers, the index step, the single-port
// corner reads and the plane fit before its result is loaded into the output register.
// A point off the terrain goes from the check straight to the output register.
// A cell write gives no result. A new item is taken only once the previous result
// sits in the output register, so a sample is finished before the next item is taken.
// Synchronous active-low reset sets the state, configuration and valid registers; the height store keeps its contents.
// ----------------------------------------------------------------------------
// heightmap_triangle_sampler
// Height store with triangle-interpolated sampling at world coordinates.
// ----------------------------------------------------------------------------
`include "heightmap_triangle_sampler_assert.svh"

module heightmap_triangle_sampler #(
    parameter int MAP_CELLS = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cell_index[15:0], cell_height[47:16], query_x[71:48], query_y[95:72]
    input  logic [95:0] s_axis_tdata,
    // operation[0]
    input  logic [0:0]  s_axis_tuser,
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // sample_height[31:0]
    output logic [31:0] m_axis_tdata,
    // inside_res[0]
    output logic [0:0]  m_axis_tuser,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW     = $clog2(MAP_CELLS);
    localparam int IW     = hts_pkg::IDX_W;
    localparam int HGT_W  = hts_pkg::HGT_W;
    localparam int POS_W  = hts_pkg::POS_W;
    localparam int FLO_W  = hts_pkg::FLO_W;
    localparam int FRAC_W = hts_pkg::FRAC_W;
    localparam int QW     = hts_pkg::QW;
    localparam logic [IW-1:0] CELLS_L = IW'(MAP_CELLS);

    hts_pkg::t_state r_state;
    hts_pkg::t_state n_state;

    // Configuration registers
    logic [12:0]              r_world_width;
    logic [12:0]              r_world_depth;
    logic [8:0]               r_map_width;
    logic [8:0]               r_map_rows;
    logic signed [15:0]       r_height_scale;

    // Sample working registers
    logic [POS_W-1:0]         r_sx;
    logic [POS_W-1:0]         r_sy;
    logic                     r_inside;
    logic [hts_pkg::DVD_W-1:0] r_dvd_x;
    logic [hts_pkg::DVD_W-1:0] r_dvd_y;
    logic [17:0]              r_total;
    logic signed [FLO_W-1:0]  r_fx;
    logic signed [FLO_W-1:0]  r_fy;
    logic [FRAC_W-1:0]        r_ox;
    logic [FRAC_W-1:0]        r_oy;
    logic signed [IW-1:0]     r_i0;
    logic signed [IW-1:0]     r_i2;
    logic [2:0]               r_cnt;
    logic                     r_zero;
    logic signed [HGT_W-1:0]  r_p [hts_pkg::CORNERS];

    // Output register
    logic                     r_m_valid;
    logic [HGT_W-1:0]         r_m_data;
    logic                     r_m_user;

    // Control decode
    logic                     in_xfer;
    logic                     cfg_wr;
    logic                     div_start;
    logic                     fit_start;
    logic                     out_load;

    // Datapath
    logic [POS_W-1:0]         c_sx_in;
    logic [POS_W-1:0]         c_sy_in;
    logic                     c_inside;
    logic [29:0]              c_mx;
    logic [29:0]              c_my;
    logic                     div_x_done;
    logic                     div_y_done;
    logic [QW-1:0]            quot_x;
    logic [QW-1:0]            quot_y;
    logic [QW-1:0]            c_nx;
    logic [QW-1:0]            c_ny;
    logic signed [19:0]       c_row;
    logic signed [IW-1:0]     c_i0;
    logic signed [IW-1:0]     c_idx;
    logic                     c_own_ok;
    logic                     c_p0_ok;
    logic signed [IW-1:0]     c_rd_sel;
    logic [1:0]               c_prev;
    logic [IW-1:0]            c_widx;
    logic                     mem_we;
    logic [AW-1:0]            mem_addr;
    logic [HGT_W-1:0]         mem_rdata;
    hts_pkg::t_fit_in         fit_in;
    logic                     fit_done;
    logic [HGT_W-1:0]         fit_height;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_world_width  <= 13'd256;
            r_world_depth  <= 13'd256;
            r_map_width    <= 9'd256;
            r_map_rows     <= 9'd256;
            r_height_scale <= 16'sd256;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                hts_pkg::REG_WORLD_WIDTH:  r_world_width  <= pwdata[12:0];
                hts_pkg::REG_WORLD_DEPTH:  r_world_depth  <= pwdata[12:0];
                hts_pkg::REG_MAP_WIDTH:    r_map_width    <= pwdata[8:0];
                hts_pkg::REG_MAP_ROWS:     r_map_rows     <= pwdata[8:0];
                hts_pkg::REG_HEIGHT_SCALE: r_height_scale <= $signed(pwdata[15:0]);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            hts_pkg::REG_WORLD_WIDTH:  prdata = 32'(r_world_width);
            hts_pkg::REG_WORLD_DEPTH:  prdata = 32'(r_world_depth);
            hts_pkg::REG_MAP_WIDTH:    prdata = 32'(r_map_width);
            hts_pkg::REG_MAP_ROWS:     prdata = 32'(r_map_rows);
            hts_pkg::REG_HEIGHT_SCALE: prdata = 32'(r_height_scale);
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hts_pkg::S_IDLE: begin
                if (in_xfer && s_axis_tuser[0] == hts_pkg::OP_SAMPLE) begin
                    n_state = hts_pkg::S_CHECK;
                end
            end
            hts_pkg::S_CHECK:    n_state = c_inside ? hts_pkg::S_DIV_GO : hts_pkg::S_DONE;
            hts_pkg::S_DIV_GO:   n_state = hts_pkg::S_DIV_WAIT;
            hts_pkg::S_DIV_WAIT: begin
                if (div_x_done) begin
                    n_state = hts_pkg::S_INDEX;
                end
            end
            hts_pkg::S_INDEX:    n_state = hts_pkg::S_READ;
            hts_pkg::S_READ: begin
                if (r_cnt == 3'(hts_pkg::CORNERS)) begin
                    n_state = hts_pkg::S_FIT_GO;
                end
            end
            hts_pkg::S_FIT_GO:   n_state = hts_pkg::S_FIT_WAIT;
            hts_pkg::S_FIT_WAIT: begin
                if (fit_done) begin
                    n_state = hts_pkg::S_DONE;
                end
            end
            hts_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = hts_pkg::S_IDLE;
                end
            end
            default: n_state = hts_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == hts_pkg::S_IDLE);
        div_start     = (r_state == hts_pkg::S_DIV_GO);
        fit_start     = (r_state == hts_pkg::S_FIT_GO);
        out_load      = (r_state == hts_pkg::S_DONE) && (!r_m_valid || m_axis_tready);
    end

    assign in_xfer = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Position, range check and divider operands
    // ------------------------------------------------------------------
    // Shift the centered point by half the world size (exact in Q.8).
    assign c_sx_in = {s_axis_tdata[71], s_axis_tdata[71:48]}
                   + {5'b0, r_world_width, 7'b0};
    assign c_sy_in = {s_axis_tdata[95], s_axis_tdata[95:72]}
                   + {5'b0, r_world_depth, 7'b0};

    // A zero world size rejects every point, so the dividers never see zero.
    assign c_inside = !r_sx[POS_W-1] && (r_sx[POS_W-2:0] < {3'b0, r_world_width, 8'b0})
                   && !r_sy[POS_W-1] && (r_sy[POS_W-2:0] < {3'b0, r_world_depth, 8'b0});

    assign c_mx = 30'(r_sx[20:0]) * 30'(r_map_width);
    assign c_my = 30'(r_sy[20:0]) * 30'(r_map_rows);

    hts_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_dvd_x),
        .i_divisor  (r_world_width),
        .o_done     (div_x_done),
        .o_quot     (quot_x)
    );

    hts_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_dvd_y),
        .i_divisor  (r_world_depth),
        .o_done     (div_y_done),
        .o_quot     (quot_y)
    );

    // The floor cell comes from the quotient less one half cell.
    assign c_nx = quot_x - QW'(32768);
    assign c_ny = quot_y - QW'(32768);

    // ------------------------------------------------------------------
    // Corner indexes and store access
    // ------------------------------------------------------------------
    assign c_row = r_fy * $signed({1'b0, r_map_width});
    assign c_i0  = IW'(c_row) + IW'(r_fx);

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    c_idx = r_i0;
            2'd1:    c_idx = r_i0 + IW'(1);
            2'd2:    c_idx = r_i2;
            default: c_idx = r_i2 + IW'(1);
        endcase
        c_own_ok = !c_idx[IW-1] && ($unsigned(c_idx) < IW'(r_total))
                && ($unsigned(c_idx) < CELLS_L);
        c_p0_ok  = !r_i0[IW-1] && ($unsigned(r_i0) < CELLS_L);
        // A corner off the map takes the first corner's height, or zero when
        // the first corner itself lies outside the store.
        c_rd_sel = c_own_ok ? c_idx : r_i0;
        c_prev   = r_cnt[1:0] - 2'd1;
    end

    assign c_widx   = IW'(s_axis_tdata[15:0]);
    assign mem_we   = in_xfer && (s_axis_tuser[0] == hts_pkg::OP_WRITE) && (c_widx < CELLS_L);
    assign mem_addr = mem_we ? c_widx[AW-1:0] : c_rd_sel[AW-1:0];

    hts_mem #(
        .DEPTH (MAP_CELLS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (s_axis_tdata[47:16]),
        .o_rdata (mem_rdata)
    );

    // ------------------------------------------------------------------
    // Working registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_state == hts_pkg::S_INDEX) begin
            r_cnt <= '0;
        end else if (r_state == hts_pkg::S_READ) begin
            r_cnt <= r_cnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_sx <= c_sx_in;
            r_sy <= c_sy_in;
        end
        if (r_state == hts_pkg::S_CHECK) begin
            r_inside <= c_inside;
            r_dvd_x  <= {c_mx, 8'h00};
            r_dvd_y  <= {c_my, 8'h00};
            r_total  <= 18'(r_map_width) * 18'(r_map_rows);
        end
        // Map coordinate n = q - 0.5; its low 16 bits are the fraction either way.
        if (r_state == hts_pkg::S_DIV_WAIT && div_x_done) begin
            r_fx <= (quot_x[QW-1:15] == '0) ? '1 : $signed({1'b0, c_nx[QW-1:16]});
            r_fy <= (quot_y[QW-1:15] == '0) ? '1 : $signed({1'b0, c_ny[QW-1:16]});
            r_ox <= quot_x[FRAC_W-1:0] ^ 16'h8000;
            r_oy <= quot_y[FRAC_W-1:0] ^ 16'h8000;
        end
        if (r_state == hts_pkg::S_INDEX) begin
            r_i0 <= c_i0;
            r_i2 <= c_i0 + IW'($signed({1'b0, r_map_width}));
        end
        if (r_state == hts_pkg::S_READ) begin
            r_zero <= !c_own_ok && !c_p0_ok;
            if (r_cnt != 3'd0) begin
                r_p[c_prev] <= r_zero ? '0 : $signed(mem_rdata);
            end
        end
    end

    // ------------------------------------------------------------------
    // Plane fit
    // ------------------------------------------------------------------
    always_comb begin
        fit_in.p0 = r_p[0];
        fit_in.p1 = r_p[1];
        fit_in.p2 = r_p[2];
        fit_in.p3 = r_p[3];
        fit_in.ox = r_ox;
        fit_in.oy = r_oy;
    end

    hts_interp u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (fit_start),
        .i_fit    (fit_in),
        .i_scale  (r_height_scale),
        .o_done   (fit_done),
        .o_height (fit_height)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_user <= r_inside;
            r_m_data <= r_inside ? fit_height : '0;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `HTS_ASSERT_IMPL(a_div_lockstep, i_clk, i_rst_n, 1'b1, div_x_done == div_y_done)
    `HTS_ASSERT_IMPL(a_div_when_waiting, i_clk, i_rst_n, div_x_done, r_state == hts_pkg::S_DIV_WAIT)
    `HTS_ASSERT_IMPL(a_fit_when_waiting, i_clk, i_rst_n, fit_done, r_state == hts_pkg::S_FIT_WAIT)
    `HTS_ASSERT_IMPL(a_outside_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0)
    `HTS_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, out_load, m_axis_tvalid && r_state == hts_pkg::S_IDLE)

endmodule

// ===== src/hts_mem.sv =====
// ----------------------------------------------------------------------------
// hts_mem
// Single-port height store with registered read data.
// ----------------------------------------------------------------------------
module hts_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_addr,
    input  logic [hts_pkg::HGT_W-1:0]  i_wdata,
    output logic [hts_pkg::HGT_W-1:0]  o_rdata
);

    logic [hts_pkg::HGT_W-1:0] r_mem [DEPTH];
    logic [hts_pkg::HGT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/hts_div.sv =====
// ----------------------------------------------------------------------------
// hts_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hts_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [hts_pkg::DVD_W-1:0]   i_dividend,
    input  logic [hts_pkg::DVS_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [hts_pkg::QW-1:0]      o_quot
);

    localparam int DVS_W = hts_pkg::DVS_W;
    localparam int QW    = hts_pkg::QW;

    logic                    r_busy;
    logic                    r_done;
    logic [hts_pkg::QCNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]        r_rem;
    logic [QW-1:0]           r_sh;
    logic [DVS_W-1:0]        r_dvs;

    logic [DVS_W:0]          c_trial;
    logic [DVS_W:0]          c_diff;
    logic                    c_ge;

    // The caller guarantees the quotient fits in QW bits, so the upper
    // dividend bits already form a partial remainder below the divisor.
    always_comb begin
        c_trial = {r_rem, r_sh[QW-1]};
        c_ge    = (c_trial >= {1'b0, r_dvs});
        c_diff  = c_trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == hts_pkg::QCNT_W'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[hts_pkg::DVD_W-1:QW];
            r_sh  <= i_dividend[QW-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= c_ge ? c_diff[DVS_W-1:0] : c_trial[DVS_W-1:0];
            r_sh  <= {r_sh[QW-2:0], c_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sh;

endmodule

// ===== src/hts_interp.sv =====
// ----------------------------------------------------------------------------
// hts_interp
// Five-stage plane fit over one cell triangle, height scaling and saturation.
// ----------------------------------------------------------------------------
module hts_interp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  hts_pkg::t_fit_in            i_fit,
    input  logic signed [15:0]          i_scale,
    output logic                        o_done,
    output logic [hts_pkg::HGT_W-1:0]   o_height
);

    localparam int HGT_W = hts_pkg::HGT_W;

    logic [4:0]               r_vld;

    logic signed [HGT_W-1:0]  r_a_p0;
    logic signed [HGT_W:0]    r_a_da;
    logic signed [HGT_W:0]    r_a_db;
    logic [15:0]              r_a_ox;
    logic [15:0]              r_a_oy;

    logic signed [HGT_W-1:0]  r_b_p0;
    logic signed [49:0]       r_b_pa;
    logic signed [49:0]       r_b_pb;

    logic signed [35:0]       r_c_h;
    logic signed [51:0]       r_d_m;
    logic [HGT_W-1:0]         r_e_out;

    logic                     c_upper;
    logic signed [HGT_W:0]    c_da;
    logic signed [HGT_W:0]    c_db;
    logic signed [51:0]       c_sum;
    logic signed [52:0]       c_rnd;
    logic signed [44:0]       c_r;
    logic                     c_fits;

    // Upper triangle (P0, P2, P3) when fy > fx, else lower (P0, P1, P3).
    always_comb begin
        c_upper = (i_fit.oy > i_fit.ox);
        if (c_upper) begin
            c_da = (HGT_W+1)'(i_fit.p3) - (HGT_W+1)'(i_fit.p2);
            c_db = (HGT_W+1)'(i_fit.p2) - (HGT_W+1)'(i_fit.p0);
        end else begin
            c_da = (HGT_W+1)'(i_fit.p1) - (HGT_W+1)'(i_fit.p0);
            c_db = (HGT_W+1)'(i_fit.p3) - (HGT_W+1)'(i_fit.p1);
        end
    end

    // Plane value in Q.32 plus one half, then floor to Q16.16 by dropping bits.
    always_comb begin
        c_sum = $signed({{4{r_b_p0[HGT_W-1]}}, r_b_p0, 16'h0000})
              + 52'(r_b_pa) + 52'(r_b_pb) + 52'sd32768;
    end

    always_comb begin
        c_rnd  = 53'(r_d_m) + 53'sd128;
        c_r    = c_rnd[52:8];
        c_fits = (&c_r[44:31]) | ~(|c_r[44:31]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a_p0 <= i_fit.p0;
            r_a_da <= c_da;
            r_a_db <= c_db;
            r_a_ox <= i_fit.ox;
            r_a_oy <= i_fit.oy;
        end
        if (r_vld[0]) begin
            r_b_p0 <= r_a_p0;
            r_b_pa <= 50'(r_a_da) * 50'($signed({1'b0, r_a_ox}));
            r_b_pb <= 50'(r_a_db) * 50'($signed({1'b0, r_a_oy}));
        end
        if (r_vld[1]) begin
            r_c_h <= c_sum[51:16];
        end
        if (r_vld[2]) begin
            r_d_m <= 52'(r_c_h) * 52'(i_scale);
        end
        if (r_vld[3]) begin
            if (c_fits) begin
                r_e_out <= c_r[HGT_W-1:0];
            end else if (c_r[44]) begin
                r_e_out <= {1'b1, {(HGT_W-1){1'b0}}};
            end else begin
                r_e_out <= {1'b0, {(HGT_W-1){1'b1}}};
            end
        end
    end

    assign o_done   = r_vld[4];
    assign o_height = r_e_out;

endmodule
